FILE: sv/cir_pkg.sv
// types and constants shared by the contact impulse resolver
// no dependencies

package cir_pkg;

    localparam int FRAC_BITS = 16;

    localparam int VEL_W  = 32;
    localparam int MASS_W = 31;
    localparam int BNC_W  = 17;
    localparam int NRM_W  = 18;
    localparam int PEN_W  = 31;
    localparam int CF_W   = 17;
    localparam int SLOP_W = 31;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 31;
    localparam int CFG_IDX_W = 1;

    localparam int DATA_IN_W  = 296;
    localparam int DATA_OUT_W = 8 * VEL_W;

    localparam int DIFF_W = VEL_W + 1;
    localparam int DOTP_W = DIFF_W + NRM_W;
    localparam int DOT_W  = DOTP_W + 1;
    localparam int VAN_W  = DIFF_W + NRM_W - 1 - FRAC_BITS;
    localparam int ONEE_W = ((FRAC_BITS > BNC_W) ? FRAC_BITS : BNC_W) + 1;
    localparam int NUM_W  = ONEE_W + VAN_W;
    localparam int SUM_W  = MASS_W + 1;
    localparam int EXD_W  = PEN_W + FRAC_BITS;
    localparam int DIV_W  = (NUM_W > EXD_W) ? NUM_W : EXD_W;
    localparam int CORR_W = PEN_W + CF_W;
    localparam int A_W    = (NUM_W > CORR_W) ? NUM_W : CORR_W;
    localparam int T_W    = VEL_W + 1 + FRAC_BITS;
    localparam int TS_W   = A_W + NRM_W - FRAC_BITS;
    localparam int TC_W   = ((TS_W > T_W) ? TS_W : T_W) + 1;
    localparam int M_W    = VEL_W + 1;
    localparam int MS_W   = T_W + MASS_W - FRAC_BITS;

    localparam logic [TC_W-1:0] T_CAP = TC_W'(1) << (VEL_W + FRAC_BITS);
    localparam logic [MS_W-1:0] M_CAP = MS_W'(1) << VEL_W;

    localparam logic [STAT_W-1:0] ST_RESOLVED = 2'd0;
    localparam logic [STAT_W-1:0] ST_SEPARATE = 2'd1;
    localparam logic [STAT_W-1:0] ST_STATIC   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CORR_FRAC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PEN_SLOP  = 1'b1;

    localparam logic [CF_W-1:0]   CF_RESET   = CF_W'((1 << FRAC_BITS) / 5);
    localparam logic [SLOP_W-1:0] SLOP_RESET = SLOP_W'((1 << FRAC_BITS) / 100);

    typedef struct packed {
        logic signed [VEL_W-1:0] v1x;
        logic signed [VEL_W-1:0] v1y;
        logic signed [VEL_W-1:0] v2x;
        logic signed [VEL_W-1:0] v2y;
        logic [MASS_W-1:0]       inv1;
        logic [MASS_W-1:0]       inv2;
        logic [NRM_W-1:0]        nxm;
        logic [NRM_W-1:0]        nym;
        logic                    nxn;
        logic                    nyn;
        logic [SUM_W-1:0]        isum;
        logic [ONEE_W-1:0]       onee;
        logic [EXD_W-1:0]        exd;
        logic [STAT_W-1:0]       status;
    } ctx_t;

endpackage

FILE: sv/cir_mul.sv
// two-stage unsigned multiplier, wide operand split into 32-bit chunks
// no dependencies

module cir_mul #(
    parameter int A_W = 32,
    parameter int B_W = 18
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] p
);

    localparam int CH_W = 32;
    localparam int NCH  = (A_W + CH_W - 1) / CH_W;
    localparam int AE_W = NCH * CH_W;
    localparam int PP_W = CH_W + B_W;
    localparam int S_W  = AE_W + B_W;

    logic [AE_W-1:0]    a_ext;
    logic [PP_W-1:0]    pp_reg [NCH];
    logic [A_W+B_W-1:0] p_reg;
    logic [A_W+B_W-1:0] p_next;

    assign a_ext = AE_W'(a);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NCH; i++) begin
                pp_reg[i] <= PP_W'(a_ext[i*CH_W +: CH_W]) * PP_W'(b);
            end
            p_reg <= p_next;
        end
    end

    always_comb begin
        logic [S_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < NCH; i++) begin
            acc = acc + (S_W'(pp_reg[i]) << (i * CH_W));
        end
        p_next = acc[A_W+B_W-1:0];
    end

    assign p = p_reg;

endmodule

FILE: sv/cir_div.sv
// pipelined restoring divider, one quotient bit per stage
// no dependencies

module cir_div #(
    parameter int N_W = 52,
    parameter int D_W = 32
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic [N_W-1:0] quo
);

    logic [D_W-1:0] rem_reg  [N_W];
    logic [D_W-1:0] den_reg  [N_W];
    logic [N_W-1:0] num_reg  [N_W];
    logic [N_W-1:0] quo_reg  [N_W];
    logic [D_W-1:0] rem_next [N_W];
    logic [D_W-1:0] den_next [N_W];
    logic [N_W-1:0] num_next [N_W];
    logic [N_W-1:0] quo_next [N_W];

    always_comb begin
        logic [D_W-1:0] rem_in;
        logic [D_W-1:0] den_in;
        logic [N_W-1:0] num_in;
        logic [N_W-1:0] quo_in;
        logic [D_W:0]   trial;
        logic           ge;
        for (int k = 0; k < N_W; k++) begin
            if (k == 0) begin
                rem_in = '0;
                den_in = den;
                num_in = num;
                quo_in = '0;
            end else begin
                rem_in = rem_reg[k-1];
                den_in = den_reg[k-1];
                num_in = num_reg[k-1];
                quo_in = quo_reg[k-1];
            end
            trial = {rem_in, num_in[N_W-1]};
            ge = trial >= {1'b0, den_in};
            rem_next[k] = ge ? D_W'(trial - {1'b0, den_in}) : trial[D_W-1:0];
            den_next[k] = den_in;
            num_next[k] = num_in << 1;
            quo_next[k] = {quo_in[N_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N_W; k++) begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_next[k];
                num_reg[k] <= num_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[N_W-1];

endmodule

FILE: sv/contact_impulse_resolver_top.sv
// contact impulse resolver: impulse and positional correction for one 2D contact
// 16 fraction bits; the 52-bit pipelined divider resolves one quotient bit per stage;
// one transfer accepted per cycle while the output is not stalled
// the whole pipeline holds while a finished result waits on the output
// reset is synchronous active low: clears valid bits and loads default registers
// depends on cir_pkg, cir_mul, cir_div

module contact_impulse_resolver_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // first_vel_x, first_vel_y, second_vel_x, second_vel_y, first_inv_mass,
    // second_inv_mass, first_bounce, second_bounce, normal_x, normal_y, penetration
    input  logic [cir_pkg::DATA_IN_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y,
    // first_shift_x, first_shift_y, second_shift_x, second_shift_y
    output logic [cir_pkg::DATA_OUT_W-1:0] m_axis_tdata,
    // status
    output logic [cir_pkg::STAT_W-1:0]     m_axis_tuser,
    input  logic                           cfg_we,
    input  logic [cir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cir_pkg::CFG_W-1:0]      cfg_data
);

    localparam int F      = cir_pkg::FRAC_BITS;
    localparam int S_IN   = 1;
    localparam int S_DOTP = 2;
    localparam int S_DOT  = 3;
    localparam int S_VAN  = 4;
    localparam int S_NUM  = S_VAN + 2;
    localparam int S_DIV  = S_NUM + cir_pkg::DIV_W;
    localparam int S_CMUL = S_DIV + 2;
    localparam int S_CORR = S_CMUL + 1;
    localparam int S_TMUL = S_CORR + 2;
    localparam int S_T    = S_TMUL + 1;
    localparam int S_MMUL = S_T + 2;
    localparam int S_M    = S_MMUL + 1;
    localparam int S_OUT  = S_M + 1;

    localparam int VW     = cir_pkg::VEL_W;
    localparam int O_INV1 = 4 * VW;
    localparam int O_INV2 = O_INV1 + cir_pkg::MASS_W;
    localparam int O_B1   = O_INV2 + cir_pkg::MASS_W;
    localparam int O_B2   = O_B1 + cir_pkg::BNC_W;
    localparam int O_NX   = O_B2 + cir_pkg::BNC_W;
    localparam int O_NY   = O_NX + cir_pkg::NRM_W;
    localparam int O_PEN  = O_NY + cir_pkg::NRM_W;

    localparam int TP_W = cir_pkg::A_W + cir_pkg::NRM_W;
    localparam int MP_W = cir_pkg::T_W + cir_pkg::MASS_W;

    logic adv;
    logic [S_OUT:1] vld_reg;

    logic [cir_pkg::CF_W-1:0]   cf_reg;
    logic [cir_pkg::SLOP_W-1:0] slop_reg;

    cir_pkg::ctx_t ctx_in;
    cir_pkg::ctx_t ctx_reg  [1:S_M];
    cir_pkg::ctx_t ctx_next [1:S_M];

    logic signed [cir_pkg::NRM_W-1:0]  nx_in, ny_in;
    logic signed [cir_pkg::DIFF_W-1:0] diffx_reg, diffy_reg;
    logic signed [cir_pkg::NRM_W-1:0]  nx_reg, ny_reg;
    logic signed [cir_pkg::DOTP_W-1:0] dxp_reg, dyp_reg;
    logic signed [cir_pkg::DOT_W-1:0]  dot_reg;
    logic signed [cir_pkg::DOT_W-1:0]  negdot;
    logic [cir_pkg::VAN_W-1:0]         van_reg;
    logic [cir_pkg::STAT_W-1:0]        status_next;

    logic [cir_pkg::NUM_W-1:0]         num;
    logic [cir_pkg::DIV_W-1:0]         quo_imp, quo_pen;
    logic [cir_pkg::A_W-1:0]           jm_reg [3];
    logic [cir_pkg::EXD_W+cir_pkg::CF_W-1:0] cprod;
    logic [cir_pkg::CORR_W-1:0]        corr_reg;

    logic [TP_W-1:0]                   tprod  [4];
    logic [cir_pkg::T_W-1:0]           t_reg  [4];
    logic [cir_pkg::T_W-1:0]           t_next [4];
    logic [MP_W-1:0]                   mprod  [8];
    logic [cir_pkg::M_W-1:0]           m_reg  [8];
    logic [cir_pkg::M_W-1:0]           m_next [8];

    logic [cir_pkg::DATA_OUT_W-1:0]    odata_reg, odata_next;
    logic [cir_pkg::STAT_W-1:0]        ostat_reg, ostat_next;

    assign adv           = !vld_reg[S_OUT] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[S_OUT];
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ostat_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cf_reg   <= cir_pkg::CF_RESET;
            slop_reg <= cir_pkg::SLOP_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                cir_pkg::REG_CORR_FRAC: cf_reg   <= cfg_data[cir_pkg::CF_W-1:0];
                cir_pkg::REG_PEN_SLOP:  slop_reg <= cfg_data[cir_pkg::SLOP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[S_OUT-1:1], s_axis_tvalid};
        end
    end

    // input unpack and first-stage arithmetic
    assign nx_in = s_axis_tdata[O_NX +: cir_pkg::NRM_W];
    assign ny_in = s_axis_tdata[O_NY +: cir_pkg::NRM_W];

    always_comb begin
        logic [cir_pkg::BNC_W-1:0] b1, b2, e;
        logic [cir_pkg::PEN_W-1:0] pen, excess;
        b1  = s_axis_tdata[O_B1 +: cir_pkg::BNC_W];
        b2  = s_axis_tdata[O_B2 +: cir_pkg::BNC_W];
        pen = s_axis_tdata[O_PEN +: cir_pkg::PEN_W];
        e   = (b1 < b2) ? b1 : b2;
        excess = (pen > slop_reg) ? pen - slop_reg : '0;
        ctx_in.v1x  = s_axis_tdata[0 +: VW];
        ctx_in.v1y  = s_axis_tdata[VW +: VW];
        ctx_in.v2x  = s_axis_tdata[2*VW +: VW];
        ctx_in.v2y  = s_axis_tdata[3*VW +: VW];
        ctx_in.inv1 = s_axis_tdata[O_INV1 +: cir_pkg::MASS_W];
        ctx_in.inv2 = s_axis_tdata[O_INV2 +: cir_pkg::MASS_W];
        ctx_in.nxn  = nx_in[cir_pkg::NRM_W-1];
        ctx_in.nyn  = ny_in[cir_pkg::NRM_W-1];
        ctx_in.nxm  = ctx_in.nxn ? cir_pkg::NRM_W'(-nx_in) : cir_pkg::NRM_W'(nx_in);
        ctx_in.nym  = ctx_in.nyn ? cir_pkg::NRM_W'(-ny_in) : cir_pkg::NRM_W'(ny_in);
        ctx_in.isum = cir_pkg::SUM_W'(ctx_in.inv1) + cir_pkg::SUM_W'(ctx_in.inv2);
        ctx_in.onee = (cir_pkg::ONEE_W'(1) << F) + cir_pkg::ONEE_W'(e);
        ctx_in.exd  = {excess, F'(0)};
        ctx_in.status = cir_pkg::ST_RESOLVED;
    end

    // relative normal velocity and status
    assign negdot = -dot_reg;

    always_comb begin
        if (!dot_reg[cir_pkg::DOT_W-1] && (dot_reg != '0)) begin
            status_next = cir_pkg::ST_SEPARATE;
        end else if (ctx_reg[S_DOT].isum == '0) begin
            status_next = cir_pkg::ST_STATIC;
        end else begin
            status_next = cir_pkg::ST_RESOLVED;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            diffx_reg <= cir_pkg::DIFF_W'(ctx_in.v2x) - cir_pkg::DIFF_W'(ctx_in.v1x);
            diffy_reg <= cir_pkg::DIFF_W'(ctx_in.v2y) - cir_pkg::DIFF_W'(ctx_in.v1y);
            nx_reg    <= nx_in;
            ny_reg    <= ny_in;
            dxp_reg   <= diffx_reg * nx_reg;
            dyp_reg   <= diffy_reg * ny_reg;
            dot_reg   <= cir_pkg::DOT_W'(dxp_reg) + cir_pkg::DOT_W'(dyp_reg);
            van_reg   <= negdot[F +: cir_pkg::VAN_W];
        end
    end

    // context carried alongside the arithmetic
    always_comb begin
        for (int k = 1; k <= S_M; k++) begin
            if (k == S_IN) begin
                ctx_next[k] = ctx_in;
            end else begin
                ctx_next[k] = ctx_reg[k-1];
                if (k == S_VAN) begin
                    ctx_next[k].status = status_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 1; k <= S_M; k++) begin
                ctx_reg[k] <= ctx_next[k];
            end
        end
    end

    // impulse numerator: (one + e) * |van|
    cir_mul #(.A_W(cir_pkg::VAN_W), .B_W(cir_pkg::ONEE_W)) u_num_mul (
        .aclk (aclk),
        .en   (adv),
        .a    (van_reg),
        .b    (ctx_reg[S_VAN].onee),
        .p    (num)
    );

    cir_div #(.N_W(cir_pkg::DIV_W), .D_W(cir_pkg::SUM_W)) u_imp_div (
        .aclk (aclk),
        .en   (adv),
        .num  (cir_pkg::DIV_W'(num)),
        .den  (ctx_reg[S_NUM].isum),
        .quo  (quo_imp)
    );

    cir_div #(.N_W(cir_pkg::DIV_W), .D_W(cir_pkg::SUM_W)) u_pen_div (
        .aclk (aclk),
        .en   (adv),
        .num  (cir_pkg::DIV_W'(ctx_reg[S_NUM].exd)),
        .den  (ctx_reg[S_NUM].isum),
        .quo  (quo_pen)
    );

    cir_mul #(.A_W(cir_pkg::EXD_W), .B_W(cir_pkg::CF_W)) u_corr_mul (
        .aclk (aclk),
        .en   (adv),
        .a    (quo_pen[cir_pkg::EXD_W-1:0]),
        .b    (cf_reg),
        .p    (cprod)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            jm_reg[0] <= cir_pkg::A_W'(quo_imp);
            jm_reg[1] <= jm_reg[0];
            jm_reg[2] <= jm_reg[1];
            corr_reg  <= cprod[cir_pkg::EXD_W+cir_pkg::CF_W-1:F];
        end
    end

    // impulse and correction along each normal axis
    for (genvar j = 0; j < 4; j++) begin : g_tmul
        cir_mul #(.A_W(cir_pkg::A_W), .B_W(cir_pkg::NRM_W)) u_t_mul (
            .aclk (aclk),
            .en   (adv),
            .a    ((j < 2) ? jm_reg[2] : cir_pkg::A_W'(corr_reg)),
            .b    ((j % 2 == 0) ? ctx_reg[S_CORR].nxm : ctx_reg[S_CORR].nym),
            .p    (tprod[j])
        );
    end

    always_comb begin
        logic [cir_pkg::TC_W-1:0] sh;
        for (int j = 0; j < 4; j++) begin
            sh = cir_pkg::TC_W'(tprod[j] >> F);
            t_next[j] = (sh > cir_pkg::T_CAP) ? cir_pkg::T_W'(cir_pkg::T_CAP)
                                              : cir_pkg::T_W'(sh);
        end
    end

    // per-body scaling by inverse mass
    for (genvar i = 0; i < 8; i++) begin : g_mmul
        cir_mul #(.A_W(cir_pkg::T_W), .B_W(cir_pkg::MASS_W)) u_m_mul (
            .aclk (aclk),
            .en   (adv),
            .a    (t_reg[i/2]),
            .b    ((i % 2 == 0) ? ctx_reg[S_T].inv1 : ctx_reg[S_T].inv2),
            .p    (mprod[i])
        );
    end

    always_comb begin
        logic [cir_pkg::MS_W-1:0] sh;
        for (int i = 0; i < 8; i++) begin
            sh = cir_pkg::MS_W'(mprod[i] >> F);
            m_next[i] = (sh > cir_pkg::M_CAP) ? cir_pkg::M_W'(cir_pkg::M_CAP)
                                              : cir_pkg::M_W'(sh);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 4; j++) begin
                t_reg[j] <= t_next[j];
            end
            for (int i = 0; i < 8; i++) begin
                m_reg[i] <= m_next[i];
            end
        end
    end

    // v plus or minus m, saturated to 32 bits
    function automatic logic [VW-1:0] sat_add(input logic signed [VW-1:0] v,
                                              input logic [cir_pkg::M_W-1:0] m,
                                              input logic add);
        logic signed [VW+2:0] w;
        logic signed [VW+2:0] mm;
        mm = $signed({2'b00, m});
        w  = add ? ((VW+3)'(v) + mm) : ((VW+3)'(v) - mm);
        if (w[VW+2:VW-1] != {4{w[VW+2]}}) begin
            sat_add = w[VW+2] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else begin
            sat_add = w[VW-1:0];
        end
    endfunction

    always_comb begin
        cir_pkg::ctx_t c;
        c = ctx_reg[S_M];
        ostat_next = c.status;
        if (c.status == cir_pkg::ST_RESOLVED) begin
            odata_next = {sat_add('0, m_reg[7], !c.nyn),
                          sat_add('0, m_reg[5], !c.nxn),
                          sat_add('0, m_reg[6], c.nyn),
                          sat_add('0, m_reg[4], c.nxn),
                          sat_add(c.v2y, m_reg[3], !c.nyn),
                          sat_add(c.v2x, m_reg[1], !c.nxn),
                          sat_add(c.v1y, m_reg[2], c.nyn),
                          sat_add(c.v1x, m_reg[0], c.nxn)};
        end else begin
            odata_next = {(4*VW)'(0), c.v2y, c.v2x, c.v1y, c.v1x};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            odata_reg <= odata_next;
            ostat_reg <= ostat_next;
        end
    end

endmodule
